// ===== rtl/core/sha_pkg.sv =====
// sha_pkg: shared constants, codes and types of the slot handle allocator.
// No dependencies; every other file of the block but sha_ram refers to it by scoped names.
package sha_pkg;

  localparam int unsigned SLOT_COUNT = 4096;
  localparam int unsigned IDX_W      = $clog2(SLOT_COUNT);
  localparam int unsigned CNT_W      = $clog2(SLOT_COUNT + 1);
  localparam int unsigned MODE_W     = 2;
  localparam int unsigned KEY_W      = 16;
  localparam int unsigned STATUS_W   = 3;
  localparam int unsigned LIVE_W     = 13;
  localparam int unsigned CMP_W      = (KEY_W > CNT_W) ? KEY_W : CNT_W;

  localparam logic [MODE_W-1:0] MODE_ALLOC   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_RELEASE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_LOOKUP  = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
  localparam logic [STATUS_W-1:0] ST_NULL     = 3'd1;
  localparam logic [STATUS_W-1:0] ST_BEYOND   = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NOT_LIVE = 3'd3;
  localparam logic [STATUS_W-1:0] ST_FULL     = 3'd4;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  typedef struct packed {
    logic capture;
    logic commit;
  } cmd_t;

endpackage

// ===== rtl/core/sha_req_if.sv =====
// sha_req_if: request channel (mode, key) with valid/ready handshake.
// Depends on sha_pkg for field widths.
interface sha_req_if;
  logic                       valid;
  logic                       ready;
  logic [sha_pkg::MODE_W-1:0] mode;
  logic [sha_pkg::KEY_W-1:0]  key;

  modport source (output valid, output mode, output key, input ready);
  modport sink   (input valid, input mode, input key, output ready);
endinterface

// ===== rtl/core/sha_rsp_if.sv =====
// sha_rsp_if: response channel (result_key, ok, status, live_count), valid/ready.
// Depends on sha_pkg for field widths.
interface sha_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [sha_pkg::KEY_W-1:0]    result_key;
  logic                         ok;
  logic [sha_pkg::STATUS_W-1:0] status;
  logic [sha_pkg::LIVE_W-1:0]   live_count;

  modport source (output valid, output result_key, output ok, output status,
                  output live_count, input ready);
  modport sink   (input valid, input result_key, input ok, input status,
                  input live_count, output ready);
endinterface

// ===== rtl/core/sha_ram.sv =====
// sha_ram: generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module sha_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/sha_ctrl.sv =====
// sha_ctrl: two-state controller; sequences capture and commit, owns rsp valid.
// Depends on sha_pkg for state_t and cmd_t.
module sha_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output sha_pkg::cmd_t cmd
);

  sha_pkg::state_t state, state_next;
  logic            rsp_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= sha_pkg::S_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      rsp_valid <= rsp_valid_next;
    end
  end

  always_comb begin
    state_next  = state;
    req_ready   = 1'b0;
    cmd.capture = 1'b0;
    cmd.commit  = 1'b0;
    unique case (state)
      sha_pkg::S_IDLE: begin
        req_ready   = 1'b1;
        cmd.capture = req_valid;
        if (req_valid) begin
          state_next = sha_pkg::S_EXEC;
        end
      end
      sha_pkg::S_EXEC: begin
        // wait for a free output slot
        cmd.commit = !rsp_valid || rsp_ready;
        if (cmd.commit) begin
          state_next = sha_pkg::S_IDLE;
        end
      end
      default: state_next = sha_pkg::S_IDLE;
    endcase
    rsp_valid_next = cmd.commit || (rsp_valid && !rsp_ready);
  end

endmodule

// ===== rtl/core/sha_datapath.sv =====
// sha_datapath: counters, live-bit and free-stack RAMs, key checks, result register.
// Depends on sha_pkg and sha_ram.
module sha_datapath (
  input  logic                         clk,
  input  logic                         rst,
  input  sha_pkg::cmd_t                cmd,
  input  logic [sha_pkg::MODE_W-1:0]   in_mode,
  input  logic [sha_pkg::KEY_W-1:0]    in_key,
  output logic [sha_pkg::KEY_W-1:0]    result_key,
  output logic                         ok,
  output logic [sha_pkg::STATUS_W-1:0] status,
  output logic [sha_pkg::LIVE_W-1:0]   live_count
);

  localparam int unsigned IDX_W = sha_pkg::IDX_W;
  localparam int unsigned CNT_W = sha_pkg::CNT_W;

  logic [sha_pkg::MODE_W-1:0] mode_q;
  logic [sha_pkg::KEY_W-1:0]  key_q;

  logic [CNT_W-1:0] high_water, high_water_next;
  logic [CNT_W-1:0] allocated_total, allocated_total_next;
  logic [CNT_W-1:0] free_depth, free_depth_next;
  logic [CNT_W-1:0] depth_m1;

  logic             live_we, live_wdata, live_rdata;
  logic [IDX_W-1:0] live_waddr, live_raddr;
  logic             stack_we;
  logic [IDX_W-1:0] stack_waddr, stack_raddr, stack_rdata;

  logic [IDX_W-1:0]            alloc_idx;
  logic [sha_pkg::KEY_W-1:0]   res_key;
  logic                        res_ok;
  logic [sha_pkg::STATUS_W-1:0] res_st;

  assign depth_m1    = free_depth - 1'b1;
  assign stack_raddr = depth_m1[IDX_W-1:0];
  assign live_raddr  = cmd.capture ? in_key[IDX_W-1:0] : key_q[IDX_W-1:0];

  sha_ram #(.WIDTH(1), .DEPTH(sha_pkg::SLOT_COUNT)) u_live (
    .clk   (clk),
    .we    (live_we),
    .waddr (live_waddr),
    .wdata (live_wdata),
    .raddr (live_raddr),
    .rdata (live_rdata)
  );

  sha_ram #(.WIDTH(IDX_W), .DEPTH(sha_pkg::SLOT_COUNT)) u_stack (
    .clk   (clk),
    .we    (stack_we),
    .waddr (stack_waddr),
    .wdata (key_q[IDX_W-1:0]),
    .raddr (stack_raddr),
    .rdata (stack_rdata)
  );

  always_comb begin
    high_water_next      = high_water;
    allocated_total_next = allocated_total;
    free_depth_next      = free_depth;
    live_we              = 1'b0;
    live_wdata           = 1'b0;
    live_waddr           = key_q[IDX_W-1:0];
    stack_we             = 1'b0;
    stack_waddr          = free_depth[IDX_W-1:0];
    alloc_idx            = high_water[IDX_W-1:0];
    res_key              = '0;
    res_ok               = 1'b0;
    res_st               = sha_pkg::ST_OK;

    if (mode_q == sha_pkg::MODE_ALLOC) begin
      priority if (free_depth != '0) begin
        alloc_idx       = stack_rdata;
        free_depth_next = depth_m1;
        res_ok          = 1'b1;
      end else if (high_water < CNT_W'(sha_pkg::SLOT_COUNT)) begin
        high_water_next = high_water + 1'b1;
        res_ok          = 1'b1;
      end else begin
        res_st = sha_pkg::ST_FULL;
      end
      if (res_ok) begin
        live_we              = cmd.commit;
        live_wdata           = 1'b1;
        live_waddr           = alloc_idx;
        allocated_total_next = allocated_total + 1'b1;
        res_key              = sha_pkg::KEY_W'(alloc_idx);
      end
    end else begin
      priority if (key_q == '0) begin
        res_st = sha_pkg::ST_NULL;
      end else if (sha_pkg::CMP_W'(key_q) >= sha_pkg::CMP_W'(high_water)) begin
        res_st = sha_pkg::ST_BEYOND;
      end else if (!live_rdata) begin
        res_st = sha_pkg::ST_NOT_LIVE;
      end else begin
        res_ok  = 1'b1;
        res_key = key_q;
      end
      if (res_ok && mode_q == sha_pkg::MODE_RELEASE) begin
        live_we              = cmd.commit;
        stack_we             = cmd.commit;
        free_depth_next      = free_depth + 1'b1;
        allocated_total_next = allocated_total - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      high_water      <= CNT_W'(1);
      allocated_total <= '0;
      free_depth      <= '0;
    end else if (cmd.commit) begin
      high_water      <= high_water_next;
      allocated_total <= allocated_total_next;
      free_depth      <= free_depth_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      mode_q <= in_mode;
      key_q  <= in_key;
    end
    if (cmd.commit) begin
      result_key <= res_key;
      ok         <= res_ok;
      status     <= res_st;
      live_count <= sha_pkg::LIVE_W'(allocated_total_next);
    end
  end

endmodule

// ===== rtl/core/slot_handle_allocator.sv =====
// slot_handle_allocator: top level; joins sha_ctrl and sha_datapath to the channels.
// Depends on sha_pkg, sha_req_if, sha_rsp_if, sha_ctrl, sha_datapath.
//
//   channel  dir  payload                                 handshake
//   req      in   mode[1:0], key[15:0]                    valid/ready
//   rsp      out  result_key[15:0], ok, status[2:0],      valid/ready
//                 live_count[12:0]
//
// One request at a time: capture (RAM read issued), then execute/write-back;
// the split is set by the registered read of the live-bit and free-stack RAMs.
// One response register; execute waits while it still holds an untaken transfer.
// Synchronous reset; no clearing pass, live bits at or above the high-water mark
// are never consulted.
module slot_handle_allocator (
  input logic clk,
  input logic rst,
  sha_req_if.sink   req,
  sha_rsp_if.source rsp
);

  sha_pkg::cmd_t cmd;

  sha_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .cmd       (cmd)
  );

  sha_datapath u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .in_mode    (req.mode),
    .in_key     (req.key),
    .result_key (rsp.result_key),
    .ok         (rsp.ok),
    .status     (rsp.status),
    .live_count (rsp.live_count)
  );

endmodule
